FILE: src/midpoint_ellipse_raster_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse raster unit
// Short forms for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTER_UNIT_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTER_UNIT_MACROS_SVH

// same-cycle implication
`define MER_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mer_pkg.sv
// ---------------------------------------------------------------------------
// mer_pkg
// Types and fixed widths shared by the ellipse raster unit.
// ---------------------------------------------------------------------------
package mer_pkg;

   localparam int RAD_W   = 8;            // semi-axis field
   localparam int RSQ_W   = 2 * RAD_W + 1;
   localparam int X_W     = 9;            // current x, unsigned
   localparam int Y_W     = 10;           // current y, signed
   localparam int SLOPE_W = 27;
   localparam int DEC_W   = 44;
   localparam int MA_W    = 2 * (X_W + 1); // holds (2x+1)^2
   localparam int MB_W    = RSQ_W;
   localparam int PROD_W  = MA_W + MB_W;

   localparam int QUEUE_DEPTH = 2;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_CLEAR,
      CMD_STEP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [RAD_W-1:0]       rx;
      logic [RAD_W-1:0]       ry;
   } cmd_ctl_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_REG1,
      PH_REG2
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EMIT,
      ST_S0,
      ST_S1,
      ST_S2,
      ST_S3,
      ST_R0,
      ST_R1,
      ST_R2,
      ST_R3,
      ST_R4,
      ST_R5
   } state_type;

endpackage

FILE: src/midpoint_ellipse_raster_unit.sv
// ---------------------------------------------------------------------------
// midpoint_ellipse_raster_unit
// Midpoint ellipse rasterizer: start beats load a shape, step beats emit
// the four symmetric pixels of the current point, or a status beat if no shape.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one beat per command. req_type 0 = start (centre and
//    semi-axes, no result); req_type 1 = step (four pixel beats, or one
//    status beat with shape_done when no shape is active).
//  - rsp channel: one result beat per cycle from an output register while
//    rsp_stall is low; last_of_run marks the final beat of each step.
//  - A two-entry command queue sits between the front classifier and the
//    stepping engine, so req beats keep flowing while results stall.
//  - A step's first result beat follows the queue write, then the engine
//    pop into the result register. A step sends four beats through the
//    single result port; the engine takes no new command until the last
//    is out. A start runs states S0 to S3 (three passes through the shared
//    multiplier). The step that crosses into region two then runs states
//    R0 to R5 to set up the region-two decision on that same multiplier.
//  - Reset: synchronous, active high; no shape active, queue empty.
//  - rsp_stall holds the result register; the engine waits, then the
//    queue fills and req_stall rises.
// ---------------------------------------------------------------------------
`include "midpoint_ellipse_raster_unit_macros.svh"

module midpoint_ellipse_raster_unit
   import mer_pkg::*;
#(
   parameter int MAX_RADIUS = 255,
   parameter int COORD_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   // request beats
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic [RAD_W-1:0]             req_radius_x,
   input  logic [RAD_W-1:0]             req_radius_y,
   // result beats
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS:0]   rsp_pixel_x,
   output logic signed [COORD_BITS:0]   rsp_pixel_y,
   output logic                         rsp_pixel_valid,
   output logic                         rsp_shape_done,
   output logic                         rsp_last_of_run
);

   localparam int CMD_W = $bits(cmd_ctl_type) + 2 * COORD_BITS;

   // front -> queue
   logic                         push_valid, push_ready;
   cmd_ctl_type                  push_ctl;
   logic signed [COORD_BITS-1:0] push_cx, push_cy;
   logic [CMD_W-1:0]             push_data;

   // queue -> back
   logic                         pop_valid, pop_ready;
   logic [CMD_W-1:0]             pop_data;
   cmd_ctl_type                  pop_ctl;
   logic signed [COORD_BITS-1:0] pop_cx, pop_cy;

   mer_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius_x (req_radius_x),
      .req_radius_y (req_radius_y),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_ctl     (push_ctl),
      .push_cx      (push_cx),
      .push_cy      (push_cy)
   );

   assign push_data = {push_ctl, push_cx, push_cy};

   mer_cmd_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_ctl, pop_cx, pop_cy} = pop_data;

   mer_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_ctl         (pop_ctl),
      .pop_cx          (pop_cx),
      .pop_cy          (pop_cy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_shape_done  (rsp_shape_done),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a step only leaves the queue when the result register can take a beat
   `MER_ASSERT_IMPLIES(a_step_pop_room, clock, reset, pop_valid && pop_ready && pop_ctl.kind == CMD_STEP, !rsp_valid || !rsp_stall, "step popped with result register blocked")
   // shape_done only ever closes a run
   `MER_ASSERT_IMPLIES(a_done_is_last, clock, reset, rsp_valid && rsp_shape_done, rsp_last_of_run, "shape_done on a beat that is not last")
   // the four pixel beats of a step follow without gaps
   `MER_ASSERT_NEXT(a_beats_contiguous, clock, reset, rsp_valid && !rsp_stall && rsp_pixel_valid && !rsp_last_of_run, rsp_valid, "gap inside a step's pixel beats")

endmodule

FILE: src/mer_front.sv
// ---------------------------------------------------------------------------
// mer_front
// Takes request beats, clamps the semi-axes and classifies each beat.
// ---------------------------------------------------------------------------
module mer_front
   import mer_pkg::*;
#(
   parameter int COORD_BITS = 11,
   parameter int MAX_RADIUS = 255
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic [RAD_W-1:0]             req_radius_x,
   input  logic [RAD_W-1:0]             req_radius_y,
   output logic                         push_valid,
   input  logic                         push_ready,
   output cmd_ctl_type                  push_ctl,
   output logic signed [COORD_BITS-1:0] push_cx,
   output logic signed [COORD_BITS-1:0] push_cy
);

   logic [RAD_W-1:0] rx_c;
   logic [RAD_W-1:0] ry_c;

   always_comb begin
      rx_c = (int'(req_radius_x) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : req_radius_x;
      ry_c = (int'(req_radius_y) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : req_radius_y;
      push_ctl.rx = rx_c;
      push_ctl.ry = ry_c;
      if (req_type == REQ_STEP) begin
         push_ctl.kind = CMD_STEP;
      end else if (rx_c == '0 || ry_c == '0) begin
         push_ctl.kind = CMD_CLEAR;  // zero axis: nothing to draw
      end else begin
         push_ctl.kind = CMD_START;
      end
   end

   assign push_valid = req_valid;
   assign push_cx    = req_center_x;
   assign push_cy    = req_center_y;
   assign req_stall  = !push_ready;

endmodule

FILE: src/mer_cmd_queue.sv
// ---------------------------------------------------------------------------
// mer_cmd_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module mer_cmd_queue
   import mer_pkg::*;
#(
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push, pop;

   assign push_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;
   assign pop_data   = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PTR_W'(wr_ff + PTR_W'(1)) : wr_ff;
      rd_in  = pop  ? PTR_W'(rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in = CNT_W'(cnt_ff + CNT_W'(push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: src/mer_back.sv
// ---------------------------------------------------------------------------
// mer_back
// Ellipse stepping engine with shared multiplier and result register.
// ---------------------------------------------------------------------------
module mer_back
   import mer_pkg::*;
#(
   parameter int COORD_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  cmd_ctl_type                  pop_ctl,
   input  logic signed [COORD_BITS-1:0] pop_cx,
   input  logic signed [COORD_BITS-1:0] pop_cy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS:0]   rsp_pixel_x,
   output logic signed [COORD_BITS:0]   rsp_pixel_y,
   output logic                         rsp_pixel_valid,
   output logic                         rsp_shape_done,
   output logic                         rsp_last_of_run
);

   localparam int PW = COORD_BITS + 12;

   // control
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] beat_ff, beat_in;
   logic       fin_ff, fin_in;
   logic       r2_ff, r2_in;
   logic       out_valid_ff, out_valid_in;

   // shape state
   logic signed [COORD_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RAD_W-1:0]             rx_ff, rx_in, ry_ff, ry_in;
   logic [RSQ_W-1:0]             rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [X_W-1:0]               x_ff, x_in, ex_ff, ex_in;
   logic signed [Y_W-1:0]        y_ff, y_in, ey_ff, ey_in;
   logic signed [SLOPE_W-1:0]    spx_ff, spx_in, spy_ff, spy_in;
   logic signed [DEC_W-1:0]      dec_ff, dec_in, acc_ff, acc_in;
   logic [MA_W-1:0]              t_ff, t_in;

   // multiplier
   logic [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]   mul_b;
   logic [PROD_W-1:0] prod_ff;

   // result register
   logic signed [COORD_BITS:0] px_ff, px_in, py_ff, py_in;
   logic pv_ff, pv_in, done_ff, done_in, last_ff, last_in;

   // step arithmetic
   logic signed [SLOPE_W-1:0] two_rx2, two_ry2, spx_a, spy_a;
   logic signed [DEC_W-1:0]   rx2_d, ry2_d, acc4, q_tmp;
   logic [X_W-1:0]            adv_x;
   logic signed [Y_W-1:0]     adv_y;
   logic signed [SLOPE_W-1:0] adv_spx, adv_spy;
   logic signed [DEC_W-1:0]   adv_dec;
   logic                      adv_enter, adv_fin;
   logic [X_W-1:0]            bmag;

   // pixel generation
   logic [X_W-1:0]        sel_x;
   logic signed [Y_W-1:0] sel_y;
   logic                  neg_x, neg_y, out_free;
   logic signed [PW-1:0]  cx_w, cy_w, ox, oy, pix_x, pix_y;

   assign two_rx2 = SLOPE_W'({rx2_ff, 1'b0});
   assign two_ry2 = SLOPE_W'({ry2_ff, 1'b0});
   assign spx_a   = spx_ff + two_ry2;
   assign spy_a   = spy_ff - two_rx2;
   assign rx2_d   = DEC_W'(rx2_ff);
   assign ry2_d   = DEC_W'(ry2_ff);
   assign out_free = !out_valid_ff || !rsp_stall;

   // one midpoint step
   always_comb begin
      adv_x     = x_ff;
      adv_y     = y_ff;
      adv_spx   = spx_ff;
      adv_spy   = spy_ff;
      adv_dec   = dec_ff;
      adv_enter = 1'b0;
      if (phase_ff == PH_REG1) begin
         adv_x   = x_ff + X_W'(1);
         adv_spx = spx_a;
         if (dec_ff[DEC_W-1]) begin
            adv_dec = dec_ff + ry2_d + DEC_W'(spx_a);
         end else begin
            adv_y   = y_ff - Y_W'(1);
            adv_spy = spy_a;
            adv_dec = dec_ff + ry2_d + DEC_W'(spx_a) - DEC_W'(spy_a);
         end
         adv_enter = !(spx_a < adv_spy);
      end else begin
         adv_y   = y_ff - Y_W'(1);
         adv_spy = spy_a;
         if (dec_ff > 0) begin
            adv_dec = dec_ff + rx2_d - DEC_W'(spy_a);
         end else begin
            adv_x   = x_ff + X_W'(1);
            adv_spx = spx_a;
            adv_dec = dec_ff + rx2_d - DEC_W'(spy_a) + DEC_W'(spx_a);
         end
      end
      adv_fin = (phase_ff == PH_REG2 || adv_enter) && adv_y[Y_W-1];
   end

   // |y-1| for region-two setup, y is never negative there
   assign bmag = (y_ff == '0) ? X_W'(1) : X_W'(y_ff - Y_W'(1));

   // region-two start value is 4d divided by four, truncated toward zero
   always_comb begin
      acc4  = acc_ff - DEC_W'({prod_ff, 2'b00});
      q_tmp = acc4 + (acc4[DEC_W-1] ? DEC_W'(3) : DEC_W'(0));
   end

   // multiplier operands
   always_comb begin
      case (state_ff)
         ST_S0: begin
            mul_a = MA_W'(rx_ff);
            mul_b = MB_W'(rx_ff);
         end
         ST_S1: begin
            mul_a = MA_W'(ry_ff);
            mul_b = MB_W'(ry_ff);
         end
         ST_S2: begin
            mul_a = MA_W'(ry_ff);
            mul_b = rx2_ff;
         end
         ST_R0: begin
            mul_a = MA_W'({x_ff, 1'b1});
            mul_b = MB_W'({x_ff, 1'b1});
         end
         ST_R1: begin
            mul_a = MA_W'(bmag);
            mul_b = MB_W'(bmag);
         end
         ST_R2: begin
            mul_a = t_ff;
            mul_b = ry2_ff;
         end
         ST_R3: begin
            mul_a = t_ff;
            mul_b = rx2_ff;
         end
         ST_R4: begin
            mul_a = MA_W'(ry2_ff);
            mul_b = rx2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // pixel of the current beat
   always_comb begin
      sel_x = (state_ff == ST_IDLE) ? x_ff : ex_ff;
      sel_y = (state_ff == ST_IDLE) ? y_ff : ey_ff;
      neg_x = beat_ff[0];
      neg_y = beat_ff[1];
      cx_w  = PW'(cx_ff);
      cy_w  = PW'(cy_ff);
      ox    = PW'(sel_x);
      oy    = PW'(sel_y);
      pix_x = neg_x ? (cx_w - ox) : (cx_w + ox);
      pix_y = neg_y ? (cy_w - oy) : (cy_w + oy);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      beat_in  = beat_ff;
      fin_in   = fin_ff;
      r2_in    = r2_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      rx2_in   = rx2_ff;
      ry2_in   = ry2_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      spx_in   = spx_ff;
      spy_in   = spy_ff;
      dec_in   = dec_ff;
      acc_in   = acc_ff;
      t_in     = t_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      pv_in    = pv_ff;
      done_in  = done_ff;
      last_in  = last_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      pop_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pop_ready = (pop_ctl.kind != CMD_STEP) || out_free;
            if (pop_valid && pop_ready) begin
               case (pop_ctl.kind)
                  CMD_START: begin
                     cx_in    = pop_cx;
                     cy_in    = pop_cy;
                     rx_in    = pop_ctl.rx;
                     ry_in    = pop_ctl.ry;
                     phase_in = PH_IDLE;
                     state_in = ST_S0;
                  end
                  CMD_CLEAR: begin
                     cx_in    = pop_cx;
                     cy_in    = pop_cy;
                     phase_in = PH_IDLE;
                  end
                  CMD_STEP: begin
                     out_valid_in = 1'b1;
                     if (phase_ff == PH_IDLE) begin
                        // status-only beat
                        px_in   = '0;
                        py_in   = '0;
                        pv_in   = 1'b0;
                        done_in = 1'b1;
                        last_in = 1'b1;
                     end else begin
                        px_in   = pix_x[COORD_BITS:0];
                        py_in   = pix_y[COORD_BITS:0];
                        pv_in   = 1'b1;
                        done_in = 1'b0;
                        last_in = 1'b0;
                        ex_in   = x_ff;
                        ey_in   = y_ff;
                        x_in    = adv_x;
                        y_in    = adv_y;
                        spx_in  = adv_spx;
                        spy_in  = adv_spy;
                        dec_in  = adv_dec;
                        fin_in  = adv_fin;
                        r2_in   = adv_enter && !adv_fin;
                        if (adv_fin) begin
                           phase_in = PH_IDLE;
                        end else if (adv_enter) begin
                           phase_in = PH_REG2;
                        end
                        beat_in  = 2'd1;
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               px_in   = pix_x[COORD_BITS:0];
               py_in   = pix_y[COORD_BITS:0];
               pv_in   = 1'b1;
               done_in = (beat_ff == 2'd3) && fin_ff;
               last_in = (beat_ff == 2'd3);
               beat_in = beat_ff + 2'd1;
               if (beat_ff == 2'd3) begin
                  state_in = r2_ff ? ST_R0 : ST_IDLE;
               end
            end
         end
         ST_S0: state_in = ST_S1;
         ST_S1: begin
            rx2_in   = RSQ_W'(prod_ff);
            state_in = ST_S2;
         end
         ST_S2: begin
            ry2_in   = RSQ_W'(prod_ff);
            state_in = ST_S3;
         end
         ST_S3: begin
            // prod holds rx2*ry
            x_in     = '0;
            y_in     = Y_W'(ry_ff);
            spx_in   = '0;
            spy_in   = SLOPE_W'({prod_ff, 1'b0});
            dec_in   = ry2_d - DEC_W'(prod_ff) + DEC_W'(rx2_ff >> 2);
            phase_in = PH_REG1;
            state_in = ST_IDLE;
         end
         ST_R0: state_in = ST_R1;
         ST_R1: begin
            t_in     = MA_W'(prod_ff);  // (2x+1)^2
            state_in = ST_R2;
         end
         ST_R2: begin
            t_in     = MA_W'(prod_ff);  // (y-1)^2
            state_in = ST_R3;
         end
         ST_R3: begin
            acc_in   = DEC_W'(prod_ff);
            state_in = ST_R4;
         end
         ST_R4: begin
            acc_in   = acc_ff + DEC_W'({prod_ff, 2'b00});
            state_in = ST_R5;
         end
         ST_R5: begin
            dec_in   = q_tmp >>> 2;
            r2_in    = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         beat_ff      <= '0;
         fin_ff       <= 1'b0;
         r2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         beat_ff      <= beat_in;
         fin_ff       <= fin_in;
         r2_ff        <= r2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rx2_ff  <= rx2_in;
      ry2_ff  <= ry2_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      ex_ff   <= ex_in;
      ey_ff   <= ey_in;
      spx_ff  <= spx_in;
      spy_ff  <= spy_in;
      dec_ff  <= dec_in;
      acc_ff  <= acc_in;
      t_ff    <= t_in;
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      px_ff   <= px_in;
      py_ff   <= py_in;
      pv_ff   <= pv_in;
      done_ff <= done_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = px_ff;
   assign rsp_pixel_y     = py_ff;
   assign rsp_pixel_valid = pv_ff;
   assign rsp_shape_done  = done_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for midpoint_ellipse_raster_unit
// Drives start and step beats, predicts every pixel beat in a scoreboard
// and checks the result stream with random request gaps and result stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import mer_pkg::*;

   localparam int COORD_W        = 11;
   localparam int RADIUS_CAP     = 255;
   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 6;
   localparam int TOTAL_BEATS    = 104;     // ~27 directed, the rest random
   localparam int QUIET_TAIL     = 20;      // no idling for the last beats
   localparam int LONG_HOLD      = 80;      // receiver back-pressure stretch
   localparam int HOLD_AT_BEAT   = 45;
   localparam int DRAIN_CYCLES   = 24;      // > start setup + region-two setup
   localparam int TIMEOUT_CYCLES = 200_000;

   // ------------------------------------------------------------------
   // Predictor and store of expected pixel beats
   // ------------------------------------------------------------------
   class ellipse_tracker;
      typedef struct packed {
         logic signed [COORD_W:0] x;
         logic signed [COORD_W:0] y;
         logic                    valid;
         logic                    done;
         logic                    last;
      } pixel_beat_type;

      pixel_beat_type expected_pixels[$];
      int             mismatches;

      phase_type phase;
      longint    centre_x, centre_y;
      longint    rx2, ry2;
      longint    cur_x, cur_y;
      longint    slope_px, slope_py;
      longint    decision;

      function new();
         phase      = PH_IDLE;
         centre_x   = 0;
         centre_y   = 0;
         rx2        = 0;
         ry2        = 0;
         cur_x      = 0;
         cur_y      = 0;
         slope_px   = 0;
         slope_py   = 0;
         decision   = 0;
         mismatches = 0;
      endfunction

      function void push_beat(longint x, longint y, bit valid, bit done, bit last);
         pixel_beat_type b;
         b.x     = x[COORD_W:0];
         b.y     = y[COORD_W:0];
         b.valid = valid;
         b.done  = done;
         b.last  = last;
         expected_pixels.insert(expected_pixels.size(), b);
      endfunction

      // one accepted request beat
      function void take_request(logic kind, logic signed [COORD_W-1:0] cx,
                                 logic signed [COORD_W-1:0] cy,
                                 logic [RAD_W-1:0] rx, logic [RAD_W-1:0] ry);
         longint rxl, ryl, x, y, a, b;
         bit     fin;
         if (kind == REQ_START) begin
            rxl = rx;
            ryl = ry;
            if (rxl > RADIUS_CAP) rxl = RADIUS_CAP;
            if (ryl > RADIUS_CAP) ryl = RADIUS_CAP;
            centre_x = cx;
            centre_y = cy;
            if (rxl == 0 || ryl == 0) begin
               phase = PH_IDLE;
               return;
            end
            rx2      = rxl * rxl;
            ry2      = ryl * ryl;
            cur_x    = 0;
            cur_y    = ryl;
            slope_px = 0;
            slope_py = 2 * rx2 * cur_y;
            decision = ry2 - rx2 * ryl + rx2 / 4;
            phase    = PH_REG1;
            return;
         end

         if (phase == PH_IDLE) begin
            push_beat(0, 0, 1'b0, 1'b1, 1'b1);
            return;
         end

         x = cur_x;
         y = cur_y;
         if (phase == PH_REG1) begin
            cur_x++;
            slope_px += 2 * ry2;
            if (decision < 0) begin
               decision += ry2 + slope_px;
            end else begin
               cur_y--;
               slope_py -= 2 * rx2;
               decision += ry2 + slope_px - slope_py;
            end
            if (!(slope_px < slope_py)) begin
               // region two decision: exact 4*d, then truncate toward zero
               a        = 2 * cur_x + 1;
               b        = cur_y - 1;
               decision = (ry2 * a * a + 4 * rx2 * b * b - 4 * rx2 * ry2) / 4;
               phase    = PH_REG2;
            end
         end else begin
            cur_y--;
            slope_py -= 2 * rx2;
            if (decision > 0) begin
               decision += rx2 - slope_py;
            end else begin
               cur_x++;
               slope_px += 2 * ry2;
               decision += rx2 - slope_py + slope_px;
            end
         end
         if (phase == PH_REG2 && cur_y < 0) phase = PH_IDLE;
         fin = (phase == PH_IDLE);

         push_beat(centre_x + x, centre_y + y, 1'b1, 1'b0, 1'b0);
         push_beat(centre_x - x, centre_y + y, 1'b1, 1'b0, 1'b0);
         push_beat(centre_x + x, centre_y - y, 1'b1, 1'b0, 1'b0);
         push_beat(centre_x - x, centre_y - y, 1'b1, fin, 1'b1);
      endfunction

      // one accepted result beat
      function void check_pixel(logic signed [COORD_W:0] x, logic signed [COORD_W:0] y,
                                logic valid, logic done, logic last);
         pixel_beat_type e;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result beat x=%0d y=%0d pv=%b sd=%b lr=%b",
                        $realtime, x, y, valid, done, last);
            return;
         end
         e = expected_pixels.pop_front();
         if (x !== e.x || y !== e.y || valid !== e.valid || done !== e.done
             || last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp x=%0d y=%0d pv=%b sd=%b lr=%b, got x=%0d y=%0d pv=%b sd=%b lr=%b",
                        $realtime, e.x, e.y, e.valid, e.done, e.last,
                        x, y, valid, done, last);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #(CLK_PERIOD / 2.0) clock = ~clock;

   logic                        req_valid    = 1'b0;
   logic                        req_stall;
   logic                        req_type     = REQ_STEP;
   logic signed [COORD_W-1:0]   req_center_x = '0;
   logic signed [COORD_W-1:0]   req_center_y = '0;
   logic [RAD_W-1:0]            req_radius_x = '0;
   logic [RAD_W-1:0]            req_radius_y = '0;

   logic                        rsp_valid;
   logic                        rsp_stall    = 1'b0;
   logic signed [COORD_W:0]     rsp_pixel_x;
   logic signed [COORD_W:0]     rsp_pixel_y;
   logic                        rsp_pixel_valid;
   logic                        rsp_shape_done;
   logic                        rsp_last_of_run;

   midpoint_ellipse_raster_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius_x    (req_radius_x),
      .req_radius_y    (req_radius_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_shape_done  (rsp_shape_done),
      .rsp_last_of_run (rsp_last_of_run)
   );

   ellipse_tracker tracker;
   int             beats_sent = 0;
   bit             quiet      = 1'b0;   // end of run: no gaps, no stalls

   // ------------------------------------------------------------------
   // Monitors: everything is sampled at the rising edge. Inputs only move
   // on the falling edge, so the samples here are stable. Results are
   // checked before the request is noted; a step's beats never show up
   // on the edge that accepts it.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_pixel_valid,
                                rsp_shape_done, rsp_last_of_run);
         if (req_valid && !req_stall)
            tracker.take_request(req_type, req_center_x, req_center_y,
                                 req_radius_x, req_radius_y);
      end
   end

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off mid-run so the
   // command queue fills and req_stall rises, then none near the end.
   // ------------------------------------------------------------------
   initial begin : rsp_side
      int hold;
      bit stall_now;
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && beats_sent >= HOLD_AT_BEAT) begin
            long_hold_done = 1'b1;
            stall_now      = 1'b1;
            hold           = LONG_HOLD;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_now = 1'b1;
            hold      = $urandom_range(1, 6);
         end else begin
            stall_now = 1'b0;
            hold      = quiet ? 1 : $urandom_range(1, 12);
         end
         rsp_stall <= stall_now;
         repeat (hold - 1) @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Sender tasks
   // ------------------------------------------------------------------
   // One request beat, with an optional idle burst ahead of it. Returns
   // after the edge that takes the beat.
   task automatic send_beat(input logic kind, input logic signed [COORD_W-1:0] cx,
                            input logic signed [COORD_W-1:0] cy,
                            input logic [RAD_W-1:0] rx, input logic [RAD_W-1:0] ry);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius_x <= rx;
      req_radius_y <= ry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (beats_sent >= TOTAL_BEATS - QUIET_TAIL) quiet = 1'b1;
   endtask

   // step beats carry junk in the shape fields; the block must ignore it
   task automatic send_steps(input int n);
      repeat (n)
         send_beat(REQ_STEP, COORD_W'($urandom), COORD_W'($urandom),
                   RAD_W'($urandom), RAD_W'($urandom));
   endtask

   // mostly tiny shapes so they run to completion; a few medium ones to
   // cross into region two after several steps, rarely a huge one
   function automatic logic [RAD_W-1:0] pick_radius();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return RAD_W'($urandom_range(1, 6));
      if (r < 19) return RAD_W'($urandom_range(7, 20));
      return RAD_W'($urandom_range(200, 255));
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : req_side
      int               pick;
      int               steps;
      logic [RAD_W-1:0] rx, ry;

      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: step with no shape after reset
      send_steps(1);
      // coordinate extremes with the largest radii
      send_beat(REQ_START, 11'sd1023, -11'sd1024, 8'd255, 8'd255);
      send_steps(2);
      // opposite extremes, unit circle run to the end and past it
      send_beat(REQ_START, -11'sd1024, 11'sd1023, 8'd1, 8'd1);
      send_steps(4);
      // zero radius on either axis leaves the block idle
      send_beat(REQ_START, 11'sd0, 11'sd0, 8'd0, 8'd5);
      send_steps(1);
      send_beat(REQ_START, 11'sd7, -11'sd7, 8'd5, 8'd0);
      send_steps(1);
      // tall shape abandoned by a new start, then a flat one to the end
      send_beat(REQ_START, -11'sd300, 11'sd200, 8'd1, 8'd6);
      send_steps(3);
      send_beat(REQ_START, 11'sd511, -11'sd512, 8'd6, 8'd1);
      send_steps(9);

      // random part: mostly whole shapes, some noise and broken runs
      while (beats_sent < TOTAL_BEATS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            rx    = pick_radius();
            ry    = pick_radius();
            steps = rx + ry + 2;
            if (steps > 24) steps = 24;
            if ($urandom_range(0, 4) == 0) steps = $urandom_range(1, steps);
            send_beat(REQ_START, COORD_W'($urandom), COORD_W'($urandom), rx, ry);
            send_steps(steps);
         end else if (pick < 16) begin
            rx = RAD_W'($urandom);
            ry = RAD_W'($urandom);
            if ($urandom_range(0, 1)) rx = '0;
            else ry = '0;
            send_beat(REQ_START, COORD_W'($urandom), COORD_W'($urandom), rx, ry);
            send_steps($urandom_range(0, 2));
         end else if (pick < 18) begin
            send_steps($urandom_range(1, 3));
         end else begin
            send_beat(REQ_START, COORD_W'($urandom), COORD_W'($urandom),
                      RAD_W'($urandom), RAD_W'($urandom));
            send_steps($urandom_range(1, 4));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // wait for every predicted beat, then watch for stray ones
      while (tracker.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
